FILE: rtl/dhcp_dp_pkg.sv
package dhcp_dp_pkg;

  // Datagram length bound; bytes at or past this index are not parsed.
  localparam int unsigned MaxDatagramBytes = 2048;
  localparam int unsigned PosW = $clog2(MaxDatagramBytes + 1);

  localparam logic [31:0] CookieValue = 32'h6382_5363;
  localparam logic [7:0]  HeaderEnd   = 8'd239;

  // Option tags with special handling
  localparam logic [7:0] TagPad     = 8'd0;
  localparam logic [7:0] TagSubnet  = 8'd1;
  localparam logic [7:0] TagTimeOff = 8'd2;
  localparam logic [7:0] TagReqIp   = 8'd50;
  localparam logic [7:0] TagMsgType = 8'd53;
  localparam logic [7:0] TagEnd     = 8'd255;

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhTag    = 3'd1,
    PhLen    = 3'd2,
    PhData   = 3'd3,
    PhDone   = 3'd4,
    PhSkip   = 3'd5,
    PhOver   = 3'd6
  } phase_e;

  typedef enum logic [3:0] {
    KindOpcode   = 4'd0,
    KindHwType   = 4'd1,
    KindHwLen    = 4'd2,
    KindXid      = 4'd3,
    KindSecs     = 4'd4,
    KindFlags    = 4'd5,
    KindCiaddr   = 4'd6,
    KindYiaddr   = 4'd7,
    KindSiaddr   = 4'd8,
    KindChaddrHi = 4'd9,
    KindChaddrLo = 4'd10,
    KindCookie   = 4'd11,
    KindOptStart = 4'd12,
    KindOptData  = 4'd13,
    KindOptsEnd  = 4'd14,
    KindDgramEnd = 4'd15
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StCookieBad = 2'd1,
    StBadLen    = 2'd2,
    StTrunc     = 2'd3
  } status_e;

  typedef struct packed {
    logic [PosW-1:0] pos;
    logic [63:0]     acc;
    phase_e          phase;
    logic [7:0]      tag;
    logic [7:0]      remaining;
    logic [7:0]      index;
    status_e         sticky;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
    logic [7:0]  code;
    logic [7:0]  size;
    logic [7:0]  dpos;
    status_e     status;
    logic        done;
  } record_t;

  localparam state_t StateReset = '{
    pos:       '0,
    acc:       '0,
    phase:     PhHeader,
    tag:       '0,
    remaining: '0,
    index:     '0,
    sticky:    StOk
  };

endpackage

FILE: rtl/dhcp_dp_in_if.sv
interface dhcp_dp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

FILE: rtl/dhcp_dp_out_if.sv
interface dhcp_dp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  record_kind;
  logic [63:0] field_value;
  logic [7:0]  option_code;
  logic [7:0]  option_size;
  logic [7:0]  data_position;
  logic [1:0]  status;
  logic        datagram_done;

  modport source (output valid, record_kind, field_value, option_code, option_size,
                  data_position, status, datagram_done, input ready);
  modport sink   (input valid, record_kind, field_value, option_code, option_size,
                  data_position, status, datagram_done, output ready);
endinterface

FILE: rtl/dhcp_dp_step.sv
module dhcp_dp_step
  import dhcp_dp_pkg::*;
(
  input  state_t     st_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output state_t     st_o,
  output logic       have_o,
  output record_t    rec_o
);

  phase_e      phase;
  logic [63:0] acc_sh;
  logic [63:0] hdr_mask;
  kind_e       hdr_kind;
  logic        trunc;
  logic        len_bad;
  logic [7:0]  rem_dec;

  assign acc_sh  = {st_i.acc[55:0], data_byte_i};
  assign rem_dec = st_i.remaining - 8'd1;

  // Fixed option lengths
  always_comb begin
    len_bad = 1'b0;
    if (st_i.tag == TagMsgType) begin
      len_bad = (data_byte_i != 8'd1);
    end else if (st_i.tag == TagSubnet || st_i.tag == TagTimeOff || st_i.tag == TagReqIp) begin
      len_bad = (data_byte_i != 8'd4);
    end
  end

  // Header field ends: kind and value width
  always_comb begin
    hdr_kind = KindOpcode;
    hdr_mask = '0;
    unique case (st_i.pos[7:0])
      8'd0:      begin hdr_kind = KindOpcode;   hdr_mask = 64'h0000_0000_0000_00ff; end
      8'd1:      begin hdr_kind = KindHwType;   hdr_mask = 64'h0000_0000_0000_00ff; end
      8'd2:      begin hdr_kind = KindHwLen;    hdr_mask = 64'h0000_0000_0000_00ff; end
      8'd7:      begin hdr_kind = KindXid;      hdr_mask = 64'h0000_0000_ffff_ffff; end
      8'd9:      begin hdr_kind = KindSecs;     hdr_mask = 64'h0000_0000_0000_ffff; end
      8'd11:     begin hdr_kind = KindFlags;    hdr_mask = 64'h0000_0000_0000_ffff; end
      8'd15:     begin hdr_kind = KindCiaddr;   hdr_mask = 64'h0000_0000_ffff_ffff; end
      8'd19:     begin hdr_kind = KindYiaddr;   hdr_mask = 64'h0000_0000_ffff_ffff; end
      8'd23:     begin hdr_kind = KindSiaddr;   hdr_mask = 64'h0000_0000_ffff_ffff; end
      8'd35:     begin hdr_kind = KindChaddrHi; hdr_mask = '1; end
      8'd43:     begin hdr_kind = KindChaddrLo; hdr_mask = '1; end
      HeaderEnd: begin hdr_kind = KindCookie;   hdr_mask = 64'h0000_0000_ffff_ffff; end
      default:   begin hdr_kind = KindOpcode;   hdr_mask = '0; end
    endcase
  end

  always_comb begin
    st_o         = st_i;
    have_o       = 1'b0;
    trunc        = 1'b0;
    rec_o.kind   = KindOpcode;
    rec_o.value  = '0;
    rec_o.code   = '0;
    rec_o.size   = '0;
    rec_o.dpos   = '0;
    rec_o.status = st_i.sticky;
    rec_o.done   = last_byte_i;

    phase = st_i.phase;
    if (phase != PhDone && phase != PhSkip && st_i.pos >= PosW'(MaxDatagramBytes)) begin
      phase = PhOver;
    end
    st_o.phase = phase;

    unique case (phase)
      PhHeader: begin
        st_o.acc = acc_sh;
        if (hdr_mask != '0) begin
          have_o      = 1'b1;
          rec_o.kind  = hdr_kind;
          rec_o.value = acc_sh & hdr_mask;
        end
        if (st_i.pos[7:0] == HeaderEnd) begin
          if (acc_sh[31:0] != CookieValue) begin
            rec_o.status = StCookieBad;
          end
          st_o.phase = PhTag;
        end else if (last_byte_i) begin
          trunc = 1'b1;
        end
      end
      PhTag: begin
        if (data_byte_i == TagEnd) begin
          have_o     = 1'b1;
          rec_o.kind = KindOptsEnd;
          rec_o.code = TagEnd;
          st_o.phase = PhDone;
        end else if (data_byte_i != TagPad) begin
          st_o.tag   = data_byte_i;
          st_o.phase = PhLen;
          trunc      = last_byte_i;
        end
      end
      PhLen: begin
        have_o     = 1'b1;
        rec_o.kind = KindOptStart;
        rec_o.code = st_i.tag;
        rec_o.size = data_byte_i;
        if (len_bad) begin
          st_o.sticky  = StBadLen;
          rec_o.status = StBadLen;
          st_o.phase   = PhSkip;
        end else if (data_byte_i == 8'd0) begin
          st_o.phase = PhTag;
        end else begin
          st_o.remaining = data_byte_i;
          st_o.index     = '0;
          st_o.phase     = PhData;
          trunc          = last_byte_i;
        end
      end
      PhData: begin
        have_o         = 1'b1;
        rec_o.kind     = KindOptData;
        rec_o.value    = {56'd0, data_byte_i};
        rec_o.code     = st_i.tag;
        rec_o.size     = st_i.remaining + st_i.index;
        rec_o.dpos     = st_i.index;
        st_o.remaining = rem_dec;
        st_o.index     = st_i.index + 8'd1;
        if (rem_dec == 8'd0) begin
          st_o.phase = PhTag;
        end else begin
          trunc = last_byte_i;
        end
      end
      PhOver: begin
        trunc = last_byte_i;
      end
      PhDone, PhSkip: begin
      end
      default: begin
      end
    endcase

    if (st_i.pos < PosW'(MaxDatagramBytes)) begin
      st_o.pos = st_i.pos + PosW'(1);
    end

    if (last_byte_i && !have_o) begin
      have_o      = 1'b1;
      rec_o.kind  = KindDgramEnd;
      rec_o.value = '0;
      rec_o.code  = '0;
      rec_o.size  = '0;
      rec_o.dpos  = '0;
    end
    if (trunc && rec_o.status != StBadLen) begin
      rec_o.status = StTrunc;
    end

    if (last_byte_i) begin
      st_o = StateReset;
    end
  end

endmodule

FILE: rtl/dhcp_datagram_parser_top.sv
// Channel | Dir | Payload                                           | Transaction
// in_i    | in  | data_byte[7:0], last_byte                         | one datagram byte
// out_o   | out | record_kind, field_value, option_code,            | one parsed record
//         |     | option_size, data_position, status, datagram_done |
//
// One byte per cycle while out_o does not stall; its record is offered in the
// cycle after the byte. The parse state updates on the byte transaction itself;
// the record goes to an output register, so in_i.ready drops only while that
// register is full and stalled. Bytes that make no record take no output slot.
// Reset (rst_ni low, asynchronous) returns the parse state to the header phase.
module dhcp_datagram_parser_top
  import dhcp_dp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  dhcp_dp_in_if.sink    in_i,
  dhcp_dp_out_if.source out_o
);

  state_t  st_q, st_d;
  record_t rec_d, rec_q;
  logic    have;
  logic    out_vld_q, out_vld_d;
  logic    in_acc;

  // Take a byte whenever the output register is empty or being drained.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  dhcp_dp_step u_step (
    .st_i        (st_q),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .st_o        (st_d),
    .have_o      (have),
    .rec_o       (rec_d)
  );

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
    if (in_acc && have) begin
      out_vld_d = 1'b1;
    end
  end

  // Parse state: control fields under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StateReset;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (in_acc) begin
        st_q <= st_d;
      end
    end
  end

  // Record payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && have) begin
      rec_q <= rec_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.record_kind   = rec_q.kind;
  assign out_o.field_value   = rec_q.value;
  assign out_o.option_code   = rec_q.code;
  assign out_o.option_size   = rec_q.size;
  assign out_o.data_position = rec_q.dpos;
  assign out_o.status        = rec_q.status;
  assign out_o.datagram_done = rec_q.done;

`ifndef SYNTHESIS
  // A last byte always yields a record flagged as the datagram's end.
  a_last_makes_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> out_vld_q && rec_q.done)
    else $error("last byte produced no closing record");

  // After a last byte the next datagram starts from the header.
  a_last_resets_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.last_byte |=> st_q.pos == '0 && st_q.phase == PhHeader
      && st_q.sticky == StOk)
    else $error("parse state not cleared after last byte");

  // Byte index saturates at the length bound.
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.pos <= PosW'(MaxDatagramBytes))
    else $error("byte position past bound");

  // Inside option data there is always at least one byte still owed.
  a_data_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase == PhData |-> st_q.remaining != 8'd0)
    else $error("data phase with no bytes remaining");
`endif

endmodule

FILE: tb/dhcp_record_checker.sv
module dhcp_record_checker
  import dhcp_dp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  dhcp_dp_in_if  in_i,
  dhcp_dp_out_if out_i,
  output int     fail_count_o,
  output int     pending_o
);

  localparam int MaxReports = 20;

  // Parser state as predicted
  logic [PosW-1:0] pos_q;
  logic [63:0]     acc_q;
  phase_e          phase_q;
  logic [7:0]      tag_q;
  logic [7:0]      remaining_q;
  logic [7:0]      index_q;
  status_e         sticky_q;

  record_t expected_records[$];
  int      fails;

  function automatic void clear_parse();
    pos_q       = '0;
    acc_q       = '0;
    phase_q     = PhHeader;
    tag_q       = '0;
    remaining_q = '0;
    index_q     = '0;
    sticky_q    = StOk;
  endfunction

  function automatic bit fixed_len_wrong(logic [7:0] tag, logic [7:0] len);
    if (tag == TagMsgType) return len != 8'd1;
    if (tag == TagSubnet || tag == TagTimeOff || tag == TagReqIp) return len != 8'd4;
    return 1'b0;
  endfunction

  // Advances the parse by one byte; returns 1 when the byte yields a record.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output record_t rec);
    bit have;
    bit trunc;
    int hw;
    have   = 1'b0;
    trunc  = 1'b0;
    hw     = 0;
    rec    = '0;
    rec.status = sticky_q;

    if (phase_q != PhDone && phase_q != PhSkip && pos_q >= MaxDatagramBytes)
      phase_q = PhOver;

    case (phase_q)
      PhHeader: begin
        acc_q = {acc_q[55:0], b};
        case (pos_q)
          0:         begin rec.kind = KindOpcode;   hw = 8;  end
          1:         begin rec.kind = KindHwType;   hw = 8;  end
          2:         begin rec.kind = KindHwLen;    hw = 8;  end
          7:         begin rec.kind = KindXid;      hw = 32; end
          9:         begin rec.kind = KindSecs;     hw = 16; end
          11:        begin rec.kind = KindFlags;    hw = 16; end
          15:        begin rec.kind = KindCiaddr;   hw = 32; end
          19:        begin rec.kind = KindYiaddr;   hw = 32; end
          23:        begin rec.kind = KindSiaddr;   hw = 32; end
          35:        begin rec.kind = KindChaddrHi; hw = 64; end
          43:        begin rec.kind = KindChaddrLo; hw = 64; end
          HeaderEnd: begin rec.kind = KindCookie;   hw = 32; end
          default: ;
        endcase
        if (hw > 0) begin
          have      = 1'b1;
          rec.value = (hw == 64) ? acc_q : acc_q & ((64'd1 << hw) - 64'd1);
        end
        if (pos_q == HeaderEnd) begin
          if (rec.value != {32'd0, CookieValue}) rec.status = StCookieBad;
          phase_q = PhTag;
        end else if (last) begin
          trunc = 1'b1;
        end
      end
      PhTag: begin
        if (b == TagEnd) begin
          have     = 1'b1;
          rec.kind = KindOptsEnd;
          rec.code = TagEnd;
          phase_q  = PhDone;
        end else if (b != TagPad) begin
          tag_q   = b;
          phase_q = PhLen;
          if (last) trunc = 1'b1;
        end
      end
      PhLen: begin
        have     = 1'b1;
        rec.kind = KindOptStart;
        rec.code = tag_q;
        rec.size = b;
        if (fixed_len_wrong(tag_q, b)) begin
          sticky_q   = StBadLen;
          rec.status = StBadLen;
          phase_q    = PhSkip;
        end else if (b == 8'd0) begin
          phase_q = PhTag;
        end else begin
          remaining_q = b;
          index_q     = '0;
          phase_q     = PhData;
          if (last) trunc = 1'b1;
        end
      end
      PhData: begin
        have        = 1'b1;
        rec.kind    = KindOptData;
        rec.value   = {56'd0, b};
        rec.code    = tag_q;
        rec.size    = remaining_q + index_q;
        rec.dpos    = index_q;
        remaining_q = remaining_q - 8'd1;
        index_q     = index_q + 8'd1;
        if (remaining_q == 8'd0) phase_q = PhTag;
        else if (last) trunc = 1'b1;
      end
      PhOver: if (last) trunc = 1'b1;
      default: ;
    endcase

    if (pos_q < MaxDatagramBytes) pos_q = pos_q + 1'b1;

    if (last && !have) begin
      have       = 1'b1;
      rec.kind   = KindDgramEnd;
      rec.value  = '0;
      rec.code   = '0;
      rec.size   = '0;
      rec.dpos   = '0;
    end
    if (trunc && rec.status != StBadLen) rec.status = StTrunc;
    rec.done = last;
    if (last) clear_parse();
    return have;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      if (fails < MaxReports)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    record_t rec;
    record_t want;
    if (!rst_ni) begin
      clear_parse();
      expected_records.delete();
    end else begin
      // byte first: its record cannot leave at the same edge
      if (in_i.valid && in_i.ready) begin
        if (parse_byte(in_i.data_byte, in_i.last_byte, rec))
          expected_records = {expected_records, rec};
      end
      if (out_i.valid && out_i.ready) begin
        if (expected_records.size() == 0) begin
          if (fails < MaxReports)
            $display("%0t: unexpected record, expected none, got kind %0d value %0h",
                     $time, out_i.record_kind, out_i.field_value);
          fails++;
        end else begin
          want = expected_records.pop_front();
          check_field("record_kind",   64'(want.kind),   64'(out_i.record_kind));
          check_field("field_value",   want.value,       out_i.field_value);
          check_field("option_code",   64'(want.code),   64'(out_i.option_code));
          check_field("option_size",   64'(want.size),   64'(out_i.option_size));
          check_field("data_position", 64'(want.dpos),   64'(out_i.data_position));
          check_field("status",        64'(want.status), 64'(out_i.status));
          check_field("datagram_done", 64'(want.done),   64'(out_i.datagram_done));
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_records.size();
  end

endmodule

FILE: tb/tb_top.sv
module tb_top;
  import dhcp_dp_pkg::*;

  // Rough ceiling on the run; the slowest legal run is well under a tenth of it.
  localparam int unsigned RunLimit = 2_000_000;
  // Random datagrams after the directed set
  localparam int RandDatagrams = 1;

  typedef enum int {StallNone, StallCoin, StallHeavy, StallPeriodic} stall_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  dhcp_dp_in_if  in_if ();
  dhcp_dp_out_if out_if ();

  dhcp_datagram_parser_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Watches both channels, predicts every record and counts mismatches.
  dhcp_record_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Datagram under construction, sent byte by byte with last on the final one
  logic [7:0] dgram[$];
  // Transactions left in the current sender burst
  int burst_left;

  logic [7:0] fixed_tags[4];
  initial fixed_tags = '{TagMsgType, TagSubnet, TagTimeOff, TagReqIp};

  // Appends one byte to the datagram under construction.
  task automatic put_byte(input logic [7:0] b);
    dgram = {dgram, b};
  endtask

  // One byte transaction. Between bursts valid drops for a random gap, which may
  // be zero; a burst now and then runs long so there are stretches with no gaps.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_dgram();
    foreach (dgram[i]) send_byte(dgram[i], i == dgram.size() - 1);
    dgram.delete();
  endtask

  // Fixed 240-byte header. fill: 0 random, 1 all zeros, 2 all ones.
  task automatic add_header(input int fill, input bit cookie_ok);
    logic [31:0] cookie;
    for (int i = 0; i < 236; i++) begin
      case (fill)
        1:       put_byte(8'h00);
        2:       put_byte(8'hFF);
        default: put_byte(8'($urandom()));
      endcase
    end
    cookie = cookie_ok ? CookieValue : $urandom();
    if (!cookie_ok && cookie == CookieValue) cookie = ~cookie;
    for (int k = 3; k >= 0; k--) put_byte(cookie[8*k +: 8]);
  endtask

  task automatic add_opt(input logic [7:0] tag, input int len);
    put_byte(tag);
    put_byte(8'(len));
    repeat (len) put_byte(8'($urandom()));
  endtask

  task automatic cut_to(input int total);
    while (dgram.size() > total) void'(dgram.pop_back());
  endtask

  // Mostly well-formed options, with a sprinkling of wrong fixed lengths.
  task automatic add_random_opt();
    int         r;
    int         len;
    logic [7:0] tag;
    r   = $urandom_range(0, 99);
    tag = fixed_tags[$urandom_range(0, 3)];
    if (r < 20) begin
      put_byte(TagPad);
    end else if (r < 50) begin
      add_opt(tag, (tag == TagMsgType) ? 1 : 4);
    end else if (r < 55) begin
      if (tag == TagMsgType) begin
        len = $urandom_range(0, 1) ? 0 : $urandom_range(2, 9);
      end else begin
        len = $urandom_range(0, 8);
        if (len >= 4) len++;
      end
      add_opt(tag, len);
    end else if (r < 95) begin
      add_opt(8'($urandom_range(3, 254)), $urandom_range(0, 12));
    end else begin
      add_opt(8'($urandom_range(3, 254)), $urandom_range(100, 255));
    end
  endtask

  task automatic random_dgram();
    int r;
    int fill;
    r    = $urandom_range(0, 99);
    fill = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0;
    add_header(fill, $urandom_range(0, 9) != 0);
    if (r < 15) begin
      // ends somewhere inside the header or right at its end
      cut_to($urandom_range(1, 240));
    end else begin
      repeat ($urandom_range(0, 8)) add_random_opt();
      if (r < 60) begin
        put_byte(TagEnd);
        repeat ($urandom_range(0, 4)) put_byte(8'($urandom()));
      end else if (r >= 80 && dgram.size() > 241) begin
        // cut at a random point among the options: on a tag, length or data byte
        cut_to($urandom_range(241, dgram.size() - 1));
      end
    end
    send_dgram();
  endtask

  // Receiver stall pattern: modes of random length, one of them never stalling.
  initial begin
    stall_e mode;
    int     left;
    out_if.ready <= 1'b0;
    mode = StallNone;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = stall_e'($urandom_range(0, 3));
        left = $urandom_range(8, 200);
      end
      left--;
      case (mode)
        StallNone:  out_if.ready <= 1'b1;
        StallCoin:  out_if.ready <= 1'($urandom_range(0, 1));
        StallHeavy: out_if.ready <= ($urandom_range(0, 3) == 0);
        default:    out_if.ready <= (left % 5) != 0;
      endcase
    end
  end

  initial begin
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.data_byte <= '0;
    in_if.last_byte <= 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Clean datagram: zero header, every fixed-length tag, a zero-length and a
    // longer option, end option and trailing junk that must be ignored.
    add_header(1, 1'b1);
    put_byte(TagPad);
    add_opt(TagMsgType, 1);
    add_opt(TagSubnet, 4);
    add_opt(TagTimeOff, 4);
    add_opt(TagReqIp, 4);
    add_opt(8'd77, 0);
    add_opt(8'd254, 8);
    put_byte(TagEnd);
    repeat (2) put_byte(8'($urandom()));
    send_dgram();

    // All-ones header with a bad cookie; parsing carries on regardless, then
    // a wrong length on message type and the rest of the datagram skipped
    add_header(2, 1'b0);
    add_opt(8'd12, 3);
    add_opt(TagMsgType, 2);
    repeat (3) put_byte(8'($urandom()));
    send_dgram();

    // One-byte datagram: truncated on the opcode
    put_byte(8'hA5);
    send_dgram();

    // Ends inside the header, early in the client hardware address
    add_header(0, 1'b1);
    cut_to(30);
    send_dgram();

    repeat (RandDatagrams) random_dgram();

    in_if.valid <= 1'b0;
    // let the checker take in the final transaction
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #(RunLimit);
    $display("tb: failure");
    $finish;
  end

endmodule
